// ===== src/abip_pkg.sv =====
`default_nettype none
package abip_pkg;

    localparam int PIX_W     = 8;
    localparam int PLANE_AW  = 2 * PIX_W;
    localparam int PLANE_DEPTH = 1 << PLANE_AW;
    localparam int SEL_W     = 3;
    localparam int VALUE_W   = 2 * PIX_W;

    localparam int DIR_BIT    = 0;
    localparam int ENABLE_BIT = 6;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    localparam logic [SEL_W-1:0] SEL_DATA     = 3'd0;
    localparam logic [SEL_W-1:0] SEL_COLUMN   = 3'd1;
    localparam logic [SEL_W-1:0] SEL_LINE     = 3'd2;
    localparam logic [SEL_W-1:0] SEL_LATCH_CF = 3'd3;
    localparam logic [SEL_W-1:0] SEL_CONTROL  = 3'd4;
    localparam logic [SEL_W-1:0] SEL_CONTROL_B = 3'd5;
    localparam logic [SEL_W-1:0] SEL_SCROLL_X = 3'd6;
    localparam logic [SEL_W-1:0] SEL_SCROLL_Y = 3'd7;

    typedef struct packed {
        logic             en;
        logic [SEL_W-1:0] sel;
        logic [PIX_W-1:0] data;
    } reg_wr_t;

    typedef struct packed {
        logic [PIX_W-1:0] column;
        logic [PIX_W-1:0] line;
        logic [PIX_W-1:0] scroll_x;
        logic [PIX_W-1:0] scroll_y;
        logic [PIX_W-1:0] palette;
        logic             enable;
    } plane_regs_t;

endpackage
`default_nettype wire

// ===== src/abip_ram.sv =====
`default_nettype none
module abip_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire                     aclk,
    input  wire                     we,
    input  wire [$clog2(Depth)-1:0] waddr,
    input  wire [Width-1:0]         wdata,
    input  wire                     re,
    input  wire [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]        rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== src/abip_regs.sv =====
`default_nettype none
module abip_regs (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire abip_pkg::reg_wr_t             wr,
    input  wire                                cfg_wr_en,
    input  wire [abip_pkg::PIX_W-1:0]          cfg_wr_data,
    output abip_pkg::plane_regs_t              regs
);

    logic [abip_pkg::PIX_W-1:0] column_reg, column_next;
    logic [abip_pkg::PIX_W-1:0] line_reg, line_next;
    logic [abip_pkg::PIX_W-1:0] control_reg, control_next;
    logic [abip_pkg::PIX_W-1:0] scroll_x_reg, scroll_x_next;
    logic [abip_pkg::PIX_W-1:0] scroll_y_reg, scroll_y_next;
    logic [abip_pkg::PIX_W-1:0] palette_reg, palette_next;

    // latch cf and control b are write-only with no effect on the plane;
    // those writes are dropped
    always_comb begin
        column_next   = column_reg;
        line_next     = line_reg;
        control_next  = control_reg;
        scroll_x_next = scroll_x_reg;
        scroll_y_next = scroll_y_reg;
        palette_next  = cfg_wr_en ? cfg_wr_data : palette_reg;
        if (wr.en) begin
            case (wr.sel)
                abip_pkg::SEL_DATA: begin
                    if (control_reg[abip_pkg::DIR_BIT]) begin
                        column_next = column_reg + 1'b1;
                    end else begin
                        line_next = line_reg + 1'b1;
                    end
                end
                abip_pkg::SEL_COLUMN:   column_next   = wr.data;
                abip_pkg::SEL_LINE:     line_next     = wr.data;
                abip_pkg::SEL_CONTROL:  control_next  = wr.data;
                abip_pkg::SEL_SCROLL_X: scroll_x_next = wr.data;
                abip_pkg::SEL_SCROLL_Y: scroll_y_next = wr.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg   <= '0;
            line_reg     <= '0;
            control_reg  <= '0;
            scroll_x_reg <= '0;
            scroll_y_reg <= '0;
            palette_reg  <= '0;
        end else begin
            column_reg   <= column_next;
            line_reg     <= line_next;
            control_reg  <= control_next;
            scroll_x_reg <= scroll_x_next;
            scroll_y_reg <= scroll_y_next;
            palette_reg  <= palette_next;
        end
    end

    assign regs.column   = column_reg;
    assign regs.line     = line_reg;
    assign regs.scroll_x = scroll_x_reg;
    assign regs.scroll_y = scroll_y_reg;
    assign regs.palette  = palette_reg;
    assign regs.enable   = control_reg[abip_pkg::ENABLE_BIT];

endmodule
`default_nettype wire

// ===== src/auto_increment_bitmap_plane.sv =====
`default_nettype none
// channel | direction | handshake        | word
// s_      | in        | s_valid/s_ready  | req_type, reg_select, write_data, screen_x/y
// m_      | out       | m_valid/m_ready  | pixel_value, pixel_opaque
// cfg_    | in        | cfg_wr_en        | palette base, no wait
//
// One word per cycle unless the output stalls or the clearing pass runs. A word's result
// reaches m_ through the frame RAM read at the edge that takes it, then the output register.
// After reset a clearing pass zeroes the 65536-byte frame RAM, one byte a cycle,
// through its single write port; s_ready stays low until the pass is done.
// A stalled output holds one result and one more in the read stage, then s_ready drops.
module auto_increment_bitmap_plane (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_valid,
    output logic                                s_ready,
    input  wire                                 s_req_type,
    input  wire [abip_pkg::SEL_W-1:0]           s_reg_select,
    input  wire [abip_pkg::PIX_W-1:0]           s_write_data,
    input  wire [abip_pkg::PIX_W-1:0]           s_screen_x,
    input  wire [abip_pkg::PIX_W-1:0]           s_screen_y,
    output logic                                m_valid,
    input  wire                                 m_ready,
    output logic [abip_pkg::VALUE_W-1:0]        m_pixel_value,
    output logic                                m_pixel_opaque,
    input  wire                                 cfg_wr_en,
    input  wire [abip_pkg::PIX_W-1:0]           cfg_wr_data
);

    abip_pkg::plane_regs_t regs;
    abip_pkg::reg_wr_t     wr;

    logic                          clearing_reg, clearing_next;
    logic [abip_pkg::PLANE_AW-1:0] clr_addr_reg, clr_addr_next;
    logic                          s1_valid_reg, s1_valid_next;
    logic                          s1_fetch_reg, s1_enable_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [abip_pkg::VALUE_W-1:0]  m_value_reg;
    logic                          m_opaque_reg;

    logic                          accept, out_free, s1_move, is_fetch;
    logic                          ram_we, ram_re;
    logic [abip_pkg::PLANE_AW-1:0] ram_waddr, ram_raddr;
    logic [abip_pkg::PIX_W-1:0]    ram_wdata, ram_rdata;
    logic [abip_pkg::PIX_W-1:0]    rd_line, rd_col;

    assign out_free = !m_valid_reg || m_ready;
    assign s1_move  = s1_valid_reg && out_free;
    assign s_ready  = !clearing_reg && (!s1_valid_reg || out_free);
    assign accept   = s_valid && s_ready;
    assign is_fetch = (s_req_type == abip_pkg::REQ_FETCH);

    assign wr.en   = accept && !is_fetch;
    assign wr.sel  = s_reg_select;
    assign wr.data = s_write_data;

    abip_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr          (wr),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .regs        (regs)
    );

    assign rd_line = s_screen_y + regs.scroll_y;
    assign rd_col  = s_screen_x + regs.scroll_x;

    always_comb begin
        ram_we    = clearing_reg || (wr.en && (s_reg_select == abip_pkg::SEL_DATA));
        ram_waddr = clearing_reg ? clr_addr_reg : {regs.line, regs.column};
        ram_wdata = clearing_reg ? '0 : s_write_data;
        ram_re    = accept && is_fetch;
        ram_raddr = {rd_line, rd_col};
    end

    abip_ram #(
        .Width (abip_pkg::PIX_W),
        .Depth (abip_pkg::PLANE_DEPTH)
    ) u_frame (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg) begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == '1) begin
                clearing_next = 1'b0;
            end
        end
        s1_valid_next = accept || (s1_valid_reg && !s1_move);
        m_valid_next  = s1_move || (m_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_fetch_reg  <= is_fetch;
            s1_enable_reg <= regs.enable;
        end
        // register writes give an all-zero word
        if (s1_move) begin
            m_value_reg  <= s1_fetch_reg ? {regs.palette, ram_rdata} : '0;
            m_opaque_reg <= s1_fetch_reg && s1_enable_reg && (ram_rdata != '0);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_value  = m_value_reg;
    assign m_pixel_opaque = m_opaque_reg;

endmodule
`default_nettype wire

// ===== src/abip_checker.sv =====
`default_nettype none
module abip_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_valid,
    input wire                          s_ready,
    input wire                          m_valid,
    input wire                          m_ready,
    input wire [abip_pkg::VALUE_W-1:0]  m_pixel_value,
    input wire                          m_pixel_opaque
);

    // no word leaves the block the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    // frame RAM clear keeps the input closed right after reset
    a_clear_blocks: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !s_ready)
        else $error("input open during clearing pass");

    // opaque only for a nonzero byte
    a_opaque_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pixel_opaque |-> m_pixel_value[abip_pkg::PIX_W-1:0] != '0)
        else $error("opaque pixel with zero byte");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_value)
                                && $stable(m_pixel_opaque))
        else $error("stalled output word changed");

endmodule

bind auto_increment_bitmap_plane abip_checker u_abip_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_pixel_value  (m_pixel_value),
    .m_pixel_opaque (m_pixel_opaque)
);
`default_nettype wire

// ===== test/plane_checker.sv =====
`default_nettype none
module plane_checker
    import abip_pkg::*;
(
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    input  wire                s_ready,
    input  wire                s_req_type,
    input  wire [SEL_W-1:0]    s_reg_select,
    input  wire [PIX_W-1:0]    s_write_data,
    input  wire [PIX_W-1:0]    s_screen_x,
    input  wire [PIX_W-1:0]    s_screen_y,
    input  wire                m_valid,
    input  wire                m_ready,
    input  wire [VALUE_W-1:0]  m_pixel_value,
    input  wire                m_pixel_opaque,
    input  wire                cfg_wr_en,
    input  wire [PIX_W-1:0]    cfg_wr_data,
    output int                 fail_count,
    output int                 words_in_flight
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               opaque;
    } pixel_word_t;

    // shadow copy of the plane and its registers
    logic [PIX_W-1:0] plane_mem [0:PLANE_DEPTH-1];
    logic [PIX_W-1:0] col_ptr, line_ptr, ctrl_a, ctrl_b, spare, scroll_x, scroll_y;
    logic [PIX_W-1:0] palette;

    pixel_word_t pending_pixels [$];
    pixel_word_t want;
    int          errs = 0;

    function automatic pixel_word_t plane_predict(
        logic req, logic [SEL_W-1:0] sel, logic [PIX_W-1:0] data,
        logic [PIX_W-1:0] sx, logic [PIX_W-1:0] sy);
        pixel_word_t      res;
        logic [PIX_W-1:0] row, col, pix;
        res = '0;
        if (req == REQ_WRITE) begin
            case (sel)
                SEL_DATA: begin
                    plane_mem[{line_ptr, col_ptr}] = data;
                    // pointers wrap independently, no carry between them
                    if (ctrl_a[DIR_BIT]) col_ptr = col_ptr + 1'b1;
                    else line_ptr = line_ptr + 1'b1;
                end
                SEL_COLUMN:    col_ptr = data;
                SEL_LINE:      line_ptr = data;
                SEL_LATCH_CF:  spare = data;
                SEL_CONTROL:   ctrl_a = data;
                SEL_CONTROL_B: ctrl_b = data;
                SEL_SCROLL_X:  scroll_x = data;
                default:       scroll_y = data;
            endcase
        end else begin
            row = sy + scroll_y;
            col = sx + scroll_x;
            pix = plane_mem[{row, col}];
            res.value = {palette, pix};
            res.opaque = ctrl_a[ENABLE_BIT] && (pix != '0);
        end
        return res;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            pending_pixels.delete();
            for (int i = 0; i < PLANE_DEPTH; i++) plane_mem[i] = '0;
            col_ptr = '0;
            line_ptr = '0;
            ctrl_a = '0;
            ctrl_b = '0;
            spare = '0;
            scroll_x = '0;
            scroll_y = '0;
            palette = '0;
        end else begin
            if (cfg_wr_en) palette = cfg_wr_data;
            // the result leaving now belongs to an older word, so pop before push
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    errs++;
                    $display("%0t: result word with nothing expected, got value %h opaque %b",
                             $time, m_pixel_value, m_pixel_opaque);
                end else begin
                    want = pending_pixels.pop_front();
                    if (m_pixel_value !== want.value) begin
                        errs++;
                        $display("%0t: pixel_value mismatch, expected %h, got %h",
                                 $time, want.value, m_pixel_value);
                    end
                    if (m_pixel_opaque !== want.opaque) begin
                        errs++;
                        $display("%0t: pixel_opaque mismatch, expected %b, got %b",
                                 $time, want.opaque, m_pixel_opaque);
                    end
                end
            end
            if (s_valid && s_ready)
                pending_pixels.push_back(plane_predict(s_req_type, s_reg_select,
                                                       s_write_data, s_screen_x, s_screen_y));
        end
        words_in_flight <= pending_pixels.size();
        fail_count <= errs;
    end

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`default_nettype none
module tb_top;
    import abip_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;   // idle limit is longer than the clearing pass
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_CYCLES    = 40;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_req_type;
    logic [SEL_W-1:0]   s_reg_select;
    logic [PIX_W-1:0]   s_write_data;
    logic [PIX_W-1:0]   s_screen_x;
    logic [PIX_W-1:0]   s_screen_y;
    logic               m_valid;
    logic               m_ready;
    logic [VALUE_W-1:0] m_pixel_value;
    logic               m_pixel_opaque;
    logic               cfg_wr_en;
    logic [PIX_W-1:0]   cfg_wr_data;

    int fail_count;
    int words_in_flight;

    bit tx_fast;
    bit rx_fast;
    bit rx_hold_req;
    int words_sent;
    int idle_cycles;

    // what the stimulus last put in the pointer and scroll registers
    logic [PIX_W-1:0] last_col, last_line, scr_x, scr_y;

    auto_increment_bitmap_plane uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_reg_select   (s_reg_select),
        .s_write_data   (s_write_data),
        .s_screen_x     (s_screen_x),
        .s_screen_y     (s_screen_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_value  (m_pixel_value),
        .m_pixel_opaque (m_pixel_opaque),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    plane_checker chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_reg_select    (s_reg_select),
        .s_write_data    (s_write_data),
        .s_screen_x      (s_screen_x),
        .s_screen_y      (s_screen_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_value   (m_pixel_value),
        .m_pixel_opaque  (m_pixel_opaque),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .words_in_flight (words_in_flight)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // result side: random backpressure, plus one long hold on request
    initial begin
        int w;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            w = rx_fast ? 0 : $urandom_range(0, 5);
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && m_ready)) @(posedge aclk);
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(logic req, logic [SEL_W-1:0] sel, logic [PIX_W-1:0] data,
                             logic [PIX_W-1:0] sx, logic [PIX_W-1:0] sy);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_reg_select <= sel;
        s_write_data <= data;
        s_screen_x   <= sx;
        s_screen_y   <= sy;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    // unused fields of each word carry random bits
    task automatic send_write(logic [SEL_W-1:0] sel, logic [PIX_W-1:0] data);
        send_word(REQ_WRITE, sel, data, 8'($urandom), 8'($urandom));
    endtask

    task automatic send_fetch(logic [PIX_W-1:0] sx, logic [PIX_W-1:0] sy);
        send_word(REQ_FETCH, 3'($urandom), 8'($urandom), sx, sy);
    endtask

    task automatic drain_pipe();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (words_in_flight != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_palette(logic [PIX_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // mostly pointer setup, data bursts and fetches aimed at the written area
    task automatic random_action();
        int r, n;
        logic [PIX_W-1:0] v;
        r = $urandom_range(0, 99);
        v = 8'($urandom);
        if (r < 8) begin
            last_col = v;
            send_write(SEL_COLUMN, v);
        end else if (r < 16) begin
            last_line = v;
            send_write(SEL_LINE, v);
        end else if (r < 20) begin
            if ($urandom_range(0, 4) != 0) v[ENABLE_BIT] = 1'b1;
            send_write(SEL_CONTROL, v);
        end else if (r < 23) begin
            send_write($urandom_range(0, 1) ? SEL_CONTROL_B : SEL_LATCH_CF, v);
        end else if (r < 27) begin
            if ($urandom_range(0, 1)) begin
                scr_x = v;
                send_write(SEL_SCROLL_X, v);
            end else begin
                scr_y = v;
                send_write(SEL_SCROLL_Y, v);
            end
        end else if (r < 50) begin
            n = $urandom_range(1, 6);
            repeat (n)
                send_write(SEL_DATA, ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
        end else if (r < 90) begin
            send_fetch(last_col - scr_x + 8'($urandom_range(0, 7)),
                       last_line - scr_y + 8'($urandom_range(0, 7)));
        end else begin
            send_word(1'($urandom), 3'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    initial begin
        int target;
        logic [PIX_W-1:0] pal;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_req_type   <= REQ_WRITE;
        s_reg_select <= SEL_DATA;
        s_write_data <= '0;
        s_screen_x   <= '0;
        s_screen_y   <= '0;
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        tx_fast = 1'b0;
        rx_fast = 1'b0;
        rx_hold_req = 1'b0;
        words_sent = 0;
        last_col = '0;
        last_line = '0;
        scr_x = '0;
        scr_y = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        write_palette(8'h00);

        // cleared plane at both corners
        send_fetch(8'h00, 8'h00);
        send_fetch(8'hFF, 8'hFF);
        // enabled, column direction; column pointer wraps from 255
        send_write(SEL_CONTROL, 8'h41);
        send_write(SEL_COLUMN, 8'hFF);
        send_write(SEL_LINE, 8'h00);
        send_write(SEL_DATA, 8'hFF);
        send_write(SEL_DATA, 8'h01);
        send_fetch(8'hFF, 8'h00);
        send_fetch(8'h00, 8'h00);
        // line direction; line pointer wraps, column stays
        send_write(SEL_CONTROL, 8'h40);
        send_write(SEL_LINE, 8'hFF);
        send_write(SEL_COLUMN, 8'h07);
        send_write(SEL_DATA, 8'h80);
        send_write(SEL_DATA, 8'h00);
        send_fetch(8'h07, 8'hFF);
        send_fetch(8'h07, 8'h00);
        // scroll wraps both axes back onto line 255, column 7
        send_write(SEL_SCROLL_X, 8'hFF);
        send_write(SEL_SCROLL_Y, 8'h01);
        send_fetch(8'h08, 8'hFE);
        send_write(SEL_CONTROL_B, 8'hA5);
        send_write(SEL_LATCH_CF, 8'h5A);
        // plane disabled: value still carries the byte, not opaque
        send_write(SEL_CONTROL, 8'h01);
        send_fetch(8'h08, 8'hFE);
        send_write(SEL_SCROLL_X, 8'h00);
        send_write(SEL_SCROLL_Y, 8'h00);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_pipe();
            case (ph)
                0:       pal = 8'hFF;
                2:       pal = 8'h00;
                3:       pal = 8'h80;
                5:       pal = 8'h01;
                default: pal = 8'($urandom);
            endcase
            write_palette(pal);
            tx_fast = (ph == 1) || (ph == 2);
            rx_fast = (ph == 1);
            // long output stall while words keep coming, so s_ready drops
            if (ph == 2) rx_hold_req = 1'b1;
            target = words_sent + PHASE_ITEMS;
            while (words_sent < target) random_action();
        end

        drain_pipe();
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
